@@ src/asm_lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// asm_lcs_pkg
// shared types, character codes and helpers for the assembler line builder
// ----------------------------------------------------------------------------
package asm_lcs_pkg;

   localparam int LINE_LEN  = 512;
   localparam int POS_W     = $clog2(LINE_LEN);
   localparam int LIMIT_W   = 10;
   localparam int JOIN_W    = 10;
   localparam int CHAR_W    = 8;
   localparam int KIND_W    = 2;
   localparam int RSP_W     = 40;

   localparam logic [LIMIT_W-1:0] LIMIT_MIN   = LIMIT_W'(2);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(LINE_LEN);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512);
   localparam logic [JOIN_W-1:0]  JOIN_MAX    = '1;

   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
   localparam logic [CHAR_W-1:0] CH_LT     = 8'h3c;
   localparam logic [CHAR_W-1:0] CH_GT     = 8'h3e;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
   localparam logic [CHAR_W-1:0] CH_BQUOTE = 8'h60;

   typedef enum logic [2:0] {
      Q_NONE   = 3'd0,
      Q_SINGLE = 3'd1,
      Q_DOUBLE = 3'd2,
      Q_BACK   = 3'd3,
      Q_ANGLE  = 3'd4
   } quote_type;

   typedef enum logic [KIND_W-1:0] {
      EV_STORE    = 2'd0,
      EV_LINE     = 2'd1,
      EV_EMPTY_END = 2'd2
   } event_type;

   // clamp the programmed limit to the usable range
   function automatic logic [LIMIT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] value);
      logic [LIMIT_W-1:0] result;
      result = value;
      if (value < LIMIT_MIN) begin
         result = LIMIT_MIN;
      end else if (value > LIMIT_MAX) begin
         result = LIMIT_MAX;
      end
      return result;
   endfunction

   // quote characters open a quote when none is open and close their own kind
   function automatic quote_type quote_toggle(input quote_type cur, input quote_type code);
      quote_type result;
      result = cur;
      if (cur == Q_NONE) begin
         result = code;
      end else if (cur == code) begin
         result = Q_NONE;
      end
      return result;
   endfunction

endpackage

@@ src/asm_line_comment_stripper.sv @@
// ----------------------------------------------------------------------------
// asm_line_comment_stripper
// builds one assembler source line from a byte stream, dropping comments
// ----------------------------------------------------------------------------
// Each request carries one source byte on req_tdata, or an end-of-input mark
// on req_tuser. A byte that is stored gives a store event with its slot; a
// newline, a NUL or end of input gives a line-complete event with the length
// and the count of joined continuation lines; end of input with nothing
// stored gives an empty-end event. Carriage returns, comment text and joins
// give no event. The line text sits in a 512 x 8 memory; the byte before the
// last stored one is prefetched every cycle so a run of joins needs no stall.
// One request is taken per cycle; an event appears on rsp in the cycle after its
// request. The rsp register holds an event while rsp_tready is low, and a new
// request is taken in the same cycle that the held event leaves; requests
// stall only while an undelivered event sits in the rsp register.
// csr_data writes the line limit (reset 512); it is taken at once and reloads
// the room count while nothing is stored in the current line. Synchronous
// reset clears the line state and the rsp valid flag; no clearing pass is run.
// ----------------------------------------------------------------------------
module asm_line_comment_stripper
   import asm_lcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [CHAR_W-1:0]   req_tdata,   // char_code
   input  logic                req_tuser,   // end_of_input
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,   // position, char_value, line_length, joined_lines
   output logic [KIND_W-1:0]   rsp_tuser,   // event_kind
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LIMIT_W-1:0]  csr_data     // line_limit
);

   logic [LIMIT_W-1:0] limit_ff;
   quote_type          quote_ff, quote_in;
   logic               skip_ff, skip_in;
   logic               stored_ff, stored_in;
   logic [LIMIT_W-1:0] wpos_ff, wpos_in;
   logic [LIMIT_W-1:0] room_ff, room_in;
   logic [JOIN_W-1:0]  join_ff, join_in;
   logic [CHAR_W-1:0]  last_ff, last_in;

   logic [CHAR_W-1:0]  line_mem [LINE_LEN];
   logic [CHAR_W-1:0]  prev_ff;
   logic [POS_W-1:0]   rd_addr;

   logic               rsp_valid_ff;
   event_type          rsp_kind_ff, kind_in;
   logic [POS_W-1:0]   rsp_pos_ff, pos_in;
   logic [CHAR_W-1:0]  rsp_char_ff, char_in;
   logic [LIMIT_W-1:0] rsp_len_ff, len_in;
   logic [JOIN_W-1:0]  rsp_join_ff, joins_in;

   logic               accept;
   logic               emit;
   logic               store;
   logic               line_end;
   logic               cfg_we;
   logic [LIMIT_W-1:0] cfg_eff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign cfg_we     = csr_valid && csr_ready;
   assign cfg_eff    = eff_limit(csr_data);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {3'b000, rsp_join_ff, rsp_len_ff, rsp_char_ff, rsp_pos_ff};

   // per-request update
   always_comb begin
      quote_in  = quote_ff;
      skip_in   = skip_ff;
      stored_in = stored_ff;
      wpos_in   = wpos_ff;
      room_in   = room_ff;
      join_in   = join_ff;
      last_in   = last_ff;
      emit      = 1'b0;
      store     = 1'b0;
      line_end  = 1'b0;
      kind_in   = EV_STORE;
      pos_in    = '0;
      char_in   = '0;
      len_in    = '0;
      joins_in  = '0;

      if (accept) begin
         if (req_tuser) begin
            emit     = 1'b1;
            line_end = 1'b1;
            if (stored_ff) begin
               kind_in  = EV_LINE;
               len_in   = wpos_ff;
               joins_in = join_ff;
            end else begin
               kind_in  = EV_EMPTY_END;
            end
         end else begin
            case (req_tdata)
               CH_SQUOTE: quote_in = quote_toggle(quote_ff, Q_SINGLE);
               CH_DQUOTE: quote_in = quote_toggle(quote_ff, Q_DOUBLE);
               CH_BQUOTE: quote_in = quote_toggle(quote_ff, Q_BACK);
               CH_LT: begin
                  if (quote_ff == Q_NONE) quote_in = Q_ANGLE;
               end
               CH_GT: begin
                  if (quote_ff == Q_ANGLE) quote_in = Q_NONE;
               end
               CH_SEMI: begin
                  if (quote_ff == Q_NONE) skip_in = 1'b1;
               end
               default: ;
            endcase

            if (req_tdata == CH_CR) begin
               // dropped
            end else if (req_tdata == CH_LF && wpos_ff != '0 && last_ff == CH_BSLASH) begin
               wpos_in = wpos_ff - LIMIT_W'(1);
               room_in = room_ff + LIMIT_W'(1);
               last_in = prev_ff;
               if (join_ff != JOIN_MAX) join_in = join_ff + JOIN_W'(1);
            end else if (req_tdata == CH_LF || req_tdata == CH_NUL) begin
               emit     = 1'b1;
               line_end = 1'b1;
               kind_in  = EV_LINE;
               len_in   = wpos_ff;
               joins_in = join_ff;
            end else if (!skip_in && wpos_ff < LIMIT_MAX) begin
               store     = 1'b1;
               emit      = 1'b1;
               kind_in   = EV_STORE;
               pos_in    = wpos_ff[POS_W-1:0];
               char_in   = req_tdata;
               wpos_in   = wpos_ff + LIMIT_W'(1);
               last_in   = req_tdata;
               stored_in = 1'b1;
               if (room_ff != '0) room_in = room_ff - LIMIT_W'(1);
               if (room_in <= LIMIT_W'(1)) skip_in = 1'b1;
            end
         end

         if (line_end) begin
            quote_in  = Q_NONE;
            skip_in   = 1'b0;
            stored_in = 1'b0;
            wpos_in   = '0;
            room_in   = eff_limit(limit_ff);
            join_in   = '0;
         end
      end
   end

   // prefetch the byte two slots below the next write position
   assign rd_addr = POS_W'(wpos_in - LIMIT_W'(2));

   always_ff @(posedge clock) begin
      if (store) begin
         line_mem[wpos_ff[POS_W-1:0]] <= req_tdata;
      end
      prev_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         quote_ff     <= Q_NONE;
         skip_ff      <= 1'b0;
         stored_ff    <= 1'b0;
         wpos_ff      <= '0;
         room_ff      <= LIMIT_RESET;
         join_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quote_ff  <= quote_in;
         skip_ff   <= skip_in;
         stored_ff <= stored_in;
         wpos_ff   <= wpos_in;
         room_ff   <= room_in;
         join_ff   <= join_in;
         last_ff   <= last_in;
         if (cfg_we) begin
            limit_ff <= csr_data;
            if (!stored_ff) room_ff <= cfg_eff;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= kind_in;
         rsp_pos_ff  <= pos_in;
         rsp_char_ff <= char_in;
         rsp_len_ff  <= len_in;
         rsp_join_ff <= joins_in;
      end
   end

endmodule
